// ===== rtl/core/sse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seeded shuffle engine package
// Shared constants, payload types and configuration register indexes.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int MAX_ITEMS_DEF  = 64;
    localparam int ITEM_WIDTH_DEF = 32;

    localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

    localparam logic [0:0] REG_SEED   = 1'b0;
    localparam logic [0:0] REG_ENABLE = 1'b1;

    typedef struct packed {
        logic [31:0] item_value;
        logic        is_last;
    } in_req_t;

    typedef struct packed {
        logic [31:0] out_value;
        logic        out_last;
        logic        overflowed;
    } out_req_t;

    // Request and answer between the sequencer and the mix/modulo unit.
    typedef struct packed {
        logic        start;
        logic [63:0] gen_state;
        logic [12:0] modulus;
    } mix_req_t;

    typedef struct packed {
        logic        done;
        logic [12:0] pick;
    } mix_rsp_t;

endpackage

// ===== rtl/core/sse_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/sse_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SplitMix64 mix and modulo unit
// Mixes one generator value with one shared 32x32 multiplier, then reduces
// the 64-bit result modulo a small count bit-serially.
// ----------------------------------------------------------------------------
module sse_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  sse_pkg::mix_req_t req,
    output sse_pkg::mix_rsp_t rsp
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_DONE = 4'd3;

    logic [3:0]  state_reg, state_next;
    logic [63:0] z_reg, z_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] k_reg, k_next;
    logic [1:0]  part_reg, part_next;
    logic        round_reg, round_next;
    logic [6:0]  bit_reg, bit_next;
    logic [13:0] rem_reg, rem_next;
    logic [12:0] m_reg, m_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] prod_sh;
    logic [63:0] acc_sum;
    logic [13:0] rem_sh;

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    // Operand selection for the shared multiplier: parts 0..2 of a
    // 64x64 low product (lo*lo, lo*hi, hi*lo).
    always_comb
    begin
        case (part_reg)
            2'd0:
            begin
                mul_a   = z_reg[31:0];
                mul_b   = k_reg[31:0];
                prod_sh = prod;
            end
            2'd1:
            begin
                mul_a   = z_reg[31:0];
                mul_b   = k_reg[63:32];
                prod_sh = {prod[31:0], 32'd0};
            end
            default:
            begin
                mul_a   = z_reg[63:32];
                mul_b   = k_reg[31:0];
                prod_sh = {prod[31:0], 32'd0};
            end
        endcase
    end

    assign acc_sum = acc_reg + prod_sh;
    assign rem_sh  = {rem_reg[12:0], z_reg[63]};

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        z_next     = z_reg;
        acc_next   = acc_reg;
        k_next     = k_reg;
        part_next  = part_reg;
        round_next = round_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        m_next     = m_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    z_next     = req.gen_state ^ (req.gen_state >> 30);
                    k_next     = sse_pkg::MIX_MUL_A;
                    m_next     = req.modulus;
                    acc_next   = '0;
                    part_next  = 2'd0;
                    round_next = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next = acc_sum;
                if (part_reg == 2'd2)
                begin
                    part_next = 2'd0;
                    acc_next  = '0;
                    if (!round_reg)
                    begin
                        z_next     = acc_sum ^ (acc_sum >> 27);
                        k_next     = sse_pkg::MIX_MUL_B;
                        round_next = 1'b1;
                    end
                    else
                    begin
                        z_next     = acc_sum ^ (acc_sum >> 31);
                        rem_next   = '0;
                        bit_next   = 7'd0;
                        state_next = S_MOD;
                    end
                end
                else
                begin
                    part_next = part_reg + 2'd1;
                end
            end
            S_MOD:
            begin
                // Restoring remainder, one bit per cycle.
                if (rem_sh >= {1'b0, m_reg})
                begin
                    rem_next = rem_sh - {1'b0, m_reg};
                end
                else
                begin
                    rem_next = rem_sh;
                end
                z_next   = {z_reg[62:0], 1'b0};
                bit_next = bit_reg + 7'd1;
                if (bit_reg == 7'd63)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg     <= z_next;
        acc_reg   <= acc_next;
        k_reg     <= k_next;
        part_reg  <= part_next;
        round_reg <= round_next;
        bit_reg   <= bit_next;
        rem_reg   <= rem_next;
        m_reg     <= m_next;
    end

    assign rsp.done = (state_reg == S_DONE);
    assign rsp.pick = rem_reg[12:0];

endmodule

// ===== rtl/core/seeded_shuffle_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seeded shuffle engine
// Collects a set of items and re-emits it in a seeded Fisher-Yates order.
// ----------------------------------------------------------------------------
// Items are loaded one per cycle into a single-port store. The item marked
// last closes the set; the block then stops taking requests and, when
// shuffling is enabled, runs one Fisher-Yates step per store index from the
// top down to 1. Each step issues a request to the shared mix unit, waits
// while that unit runs six 32x32 multiplier passes, a bit-serial modulo over
// the 64-bit result and a done state, and then swaps the two items over the
// single store port. On output each item passes through a store read and
// then the output register, and can be held by an output stall.
// Items beyond MAX_ITEMS are dropped and flagged on every result of the set.
module seeded_shuffle_engine_unit #(
    parameter int MAX_ITEMS  = sse_pkg::MAX_ITEMS_DEF,
    parameter int ITEM_WIDTH = sse_pkg::ITEM_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sse_pkg::in_req_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output sse_pkg::out_req_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_MIX   = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_SWAP  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_HOLD  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  drop_reg, drop_next;
    logic [63:0]           gen_reg, gen_next;
    logic [63:0]           seed_reg;
    logic                  enable_reg;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]         pick_reg, pick_next;
    logic [1:0]            sw_reg, sw_next;
    logic [ITEM_WIDTH-1:0] top_val_reg, top_val_next;
    logic                  ovalid_reg, ovalid_next;
    sse_pkg::out_req_t     odata_reg, odata_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    sse_pkg::mix_req_t     mreq;
    sse_pkg::mix_rsp_t     mrsp;

    logic                  in_acc;
    logic [31:0]           rdata_ext;

    sse_ram #(
        .WIDTH(ITEM_WIDTH),
        .DEPTH(MAX_ITEMS)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    sse_mix u_mix (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mreq),
        .rsp  (mrsp)
    );

    assign in_stall  = (state_reg != S_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    // Store words narrower or wider than 32 bits are fitted to the output.
    assign rdata_ext = 32'(ram_rdata);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sse_pkg::REG_SEED:   seed_reg   <= cfg_data;
                sse_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                default:             seed_reg   <= seed_reg;
            endcase
        end
    end

    // Main sequencer: load, shuffle steps, emit.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        drop_next     = drop_reg;
        gen_next      = gen_reg;
        idx_next      = idx_reg;
        pick_next     = pick_reg;
        sw_next       = sw_reg;
        top_val_next  = top_val_reg;
        ovalid_next   = ovalid_reg;
        odata_next    = odata_reg;
        ram_we        = 1'b0;
        ram_addr      = idx_reg[AW-1:0];
        ram_wdata     = top_val_reg;
        mreq.start     = 1'b0;
        mreq.gen_state = gen_reg + sse_pkg::GOLDEN_INC;
        mreq.modulus   = 13'(idx_reg);

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                ram_addr  = count_reg[AW-1:0];
                ram_wdata = ITEM_WIDTH'(in_data.item_value);
                if (in_acc)
                begin
                    if (count_reg < CAP)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (in_data.is_last)
                    begin
                        gen_next = seed_reg;
                        if (enable_reg && (count_next > CW'(1)))
                        begin
                            idx_next   = count_next;
                            state_next = S_MIX;
                        end
                        else
                        begin
                            idx_next   = '0;
                            sw_next    = 2'd0;
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_MIX:
            begin
                mreq.start = 1'b1;
                gen_next   = gen_reg + sse_pkg::GOLDEN_INC;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mrsp.done)
                begin
                    pick_next  = mrsp.pick[AW-1:0];
                    sw_next    = 2'd0;
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                // Read top, read pick, write top, write pick.
                case (sw_reg)
                    2'd0:
                    begin
                        ram_addr = AW'(idx_reg - 1'b1);
                    end
                    2'd1:
                    begin
                        ram_addr     = pick_reg;
                        top_val_next = ram_rdata;
                    end
                    2'd2:
                    begin
                        ram_addr  = AW'(idx_reg - 1'b1);
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata;
                    end
                    default:
                    begin
                        ram_addr  = pick_reg;
                        ram_we    = 1'b1;
                        ram_wdata = top_val_reg;
                    end
                endcase
                sw_next = sw_reg + 2'd1;
                if (sw_reg == 2'd3)
                begin
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg == CW'(2))
                    begin
                        idx_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_MIX;
                    end
                end
            end
            S_EMIT:
            begin
                // Issue the store read for the next position.
                ram_addr   = idx_reg[AW-1:0];
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                ram_addr = idx_reg[AW-1:0];
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next          = 1'b1;
                    odata_next.out_value = rdata_ext;
                    odata_next.out_last  = (idx_reg + 1'b1 == count_reg);
                    odata_next.overflowed = drop_reg;
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        idx_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            count_reg  <= '0;
            drop_reg   <= 1'b0;
            gen_reg    <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            drop_reg   <= drop_next;
            gen_reg    <= gen_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg    <= pick_next;
        sw_reg      <= sw_next;
        top_val_reg <= top_val_next;
        odata_reg   <= odata_next;
    end

endmodule
